@@ design/sacs_pkg.sv @@
// Shared types and codes for the suffix automaton common substring block.
`default_nettype none
package sacs_pkg;

  localparam int OP_W  = 2;
  localparam int SYM_W = 5;
  localparam int OUT_W = 11;

  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_EXTEND = 2'd1;
  localparam logic [OP_W-1:0] OP_MATCH  = 2'd2;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_ROW,
    S_EX_RD, S_EX_CHK, S_EX_QCHK,
    S_CL_L1, S_CL_L2, S_CL_L3, S_CP_RD, S_CP_WR,
    S_RD_RD, S_RD_CHK, S_EX_FIN,
    S_M_RD, S_M_CHK,
    S_DONE
  } state_t;

  typedef enum logic [4:0] {
    C_NONE, C_CLEAR, C_EXT_SKIP, C_EXT_START, C_ROW,
    C_LINK_ROOT, C_EX_RD, C_EX_SET, C_EX_Q, C_LINK_Q, C_CLONE,
    C_CL_L1, C_CL_L2, C_CL_L3, C_CP_RD, C_CP_WR,
    C_RD_RD, C_RD_SET, C_EX_FIN,
    C_M_START, C_M_ZERO, C_M_RD, C_M_WALK, C_M_HIT,
    C_OP3, C_PUSH
  } cmd_t;

  typedef struct packed {
    logic p_none;
    logic t_none;
    logic t_eq_q;
    logic len_eq;
    logic idx_last;
    logic sym_ok;
    logic ext_full;
    logic out_free;
  } ctl_status_t;

endpackage
`default_nettype wire

@@ design/sacs_if.sv @@
// Request and response channel interfaces.
`default_nettype none
interface sacs_req_if;
  logic                       valid;
  logic                       ready;
  logic [sacs_pkg::OP_W-1:0]  operation;
  logic [sacs_pkg::SYM_W-1:0] symbol;
  modport source (output valid, output operation, output symbol, input ready);
  modport sink   (input valid, input operation, input symbol, output ready);
endinterface

interface sacs_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [sacs_pkg::OUT_W-1:0] best_length;
  logic [sacs_pkg::OUT_W-1:0] match_length;
  logic                       status;
  modport source (output valid, output best_length, output match_length, output status,
                  input ready);
  modport sink   (input valid, input best_length, input match_length, input status,
                  output ready);
endinterface
`default_nettype wire

@@ design/suffix_automaton_common_substring.sv @@
// Top level: suffix automaton builder and longest common substring matcher.
//
//  channel | dir | fields                                  | handshake
//  req     | in  | operation[1:0], symbol[4:0]             | valid/ready
//  rsp     | out | best_length[10:0], match_length[10:0],  | valid/ready
//          |     | status                                  |
//
// One item at a time; each takes one response. The reset pass writes the root
// row before req.ready rises; a clear rewrites it. An extend writes the new
// state's row, then walks suffix links from the last state, setting missing
// transitions, until a transition exists or the walk passes the root; if the
// state found has the wrong length, a clone copies its link and transitions
// and a second walk redirects transitions to the clone. A match follows suffix
// links until a transition is found or it falls back to the root. Ignored or
// dropped extends, an out-of-range match and the unused code go straight to
// the response. A finished response waits in its register while the next
// request is taken; rsp stalls only delay the end of the following item.
`default_nettype none
module suffix_automaton_common_substring #(
  parameter int MAX_TEXT = 1024,
  parameter int ALPHABET = 26
) (
  input  wire logic  clk,
  input  wire logic  rst,
  sacs_req_if.sink   req,
  sacs_rsp_if.source rsp
);

  sacs_pkg::cmd_t        cmd;
  sacs_pkg::ctl_status_t st;

  // Controller: decode the request, then step the walk loops.
  sacs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_op    (req.operation),
    .st       (st),
    .in_ready (req.ready),
    .cmd      (cmd)
  );

  // Datapath: stores, walk pointers, match state and response register.
  sacs_dpath #(
    .MAX_TEXT (MAX_TEXT),
    .ALPHABET (ALPHABET)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sym_in     (req.symbol),
    .out_ready  (rsp.ready),
    .st         (st),
    .out_valid  (rsp.valid),
    .out_best   (rsp.best_length),
    .out_match  (rsp.match_length),
    .out_status (rsp.status)
  );

endmodule
`default_nettype wire

@@ design/sacs_ctrl.sv @@
// Sequencer for clear, extend and match operations.
`default_nettype none
module sacs_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  input  wire logic [sacs_pkg::OP_W-1:0] in_op,
  input  wire sacs_pkg::ctl_status_t     st,
  output logic                           in_ready,
  output sacs_pkg::cmd_t                 cmd
);

  sacs_pkg::state_t state, state_next;
  logic ext_flag;
  logic boot;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= sacs_pkg::S_INIT;
      ext_flag <= 1'b0;
      boot     <= 1'b1;
    end else begin
      state <= state_next;
      if (state == sacs_pkg::S_IDLE && in_valid) begin
        ext_flag <= (in_op == sacs_pkg::OP_EXTEND);
      end
      if (state == sacs_pkg::S_ROW && st.idx_last) begin
        boot <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      sacs_pkg::S_INIT: state_next = sacs_pkg::S_ROW;
      sacs_pkg::S_IDLE: begin
        if (in_valid) begin
          case (in_op)
            sacs_pkg::OP_CLEAR:  state_next = sacs_pkg::S_ROW;
            sacs_pkg::OP_EXTEND: state_next = (!st.sym_ok || st.ext_full) ?
                                              sacs_pkg::S_DONE : sacs_pkg::S_ROW;
            sacs_pkg::OP_MATCH:  state_next = st.sym_ok ? sacs_pkg::S_M_RD : sacs_pkg::S_DONE;
            default:             state_next = sacs_pkg::S_DONE;
          endcase
        end
      end
      sacs_pkg::S_ROW: begin
        if (st.idx_last) begin
          if (boot)          state_next = sacs_pkg::S_IDLE;
          else if (ext_flag) state_next = sacs_pkg::S_EX_RD;
          else               state_next = sacs_pkg::S_DONE;
        end
      end
      sacs_pkg::S_EX_RD:   state_next = st.p_none ? sacs_pkg::S_EX_FIN : sacs_pkg::S_EX_CHK;
      sacs_pkg::S_EX_CHK:  state_next = st.t_none ? sacs_pkg::S_EX_RD : sacs_pkg::S_EX_QCHK;
      sacs_pkg::S_EX_QCHK: state_next = st.len_eq ? sacs_pkg::S_EX_FIN : sacs_pkg::S_CL_L1;
      sacs_pkg::S_CL_L1:   state_next = sacs_pkg::S_CL_L2;
      sacs_pkg::S_CL_L2:   state_next = sacs_pkg::S_CL_L3;
      sacs_pkg::S_CL_L3:   state_next = sacs_pkg::S_CP_RD;
      sacs_pkg::S_CP_RD:   state_next = sacs_pkg::S_CP_WR;
      sacs_pkg::S_CP_WR:   state_next = st.idx_last ? sacs_pkg::S_RD_RD : sacs_pkg::S_CP_RD;
      sacs_pkg::S_RD_RD:   state_next = st.p_none ? sacs_pkg::S_EX_FIN : sacs_pkg::S_RD_CHK;
      sacs_pkg::S_RD_CHK:  state_next = st.t_eq_q ? sacs_pkg::S_RD_RD : sacs_pkg::S_EX_FIN;
      sacs_pkg::S_EX_FIN:  state_next = sacs_pkg::S_DONE;
      sacs_pkg::S_M_RD:    state_next = st.p_none ? sacs_pkg::S_DONE : sacs_pkg::S_M_CHK;
      sacs_pkg::S_M_CHK:   state_next = st.t_none ? sacs_pkg::S_M_RD : sacs_pkg::S_DONE;
      sacs_pkg::S_DONE:    state_next = st.out_free ? sacs_pkg::S_IDLE : sacs_pkg::S_DONE;
      default:             state_next = sacs_pkg::S_INIT;
    endcase
  end

  always_comb begin
    cmd      = sacs_pkg::C_NONE;
    in_ready = (state == sacs_pkg::S_IDLE);
    case (state)
      sacs_pkg::S_INIT: cmd = sacs_pkg::C_CLEAR;
      sacs_pkg::S_IDLE: begin
        if (in_valid) begin
          case (in_op)
            sacs_pkg::OP_CLEAR:  cmd = sacs_pkg::C_CLEAR;
            sacs_pkg::OP_EXTEND: cmd = (!st.sym_ok || st.ext_full) ?
                                       sacs_pkg::C_EXT_SKIP : sacs_pkg::C_EXT_START;
            sacs_pkg::OP_MATCH:  cmd = st.sym_ok ? sacs_pkg::C_M_START : sacs_pkg::C_M_ZERO;
            default:             cmd = sacs_pkg::C_OP3;
          endcase
        end
      end
      sacs_pkg::S_ROW:     cmd = sacs_pkg::C_ROW;
      sacs_pkg::S_EX_RD:   cmd = st.p_none ? sacs_pkg::C_LINK_ROOT : sacs_pkg::C_EX_RD;
      sacs_pkg::S_EX_CHK:  cmd = st.t_none ? sacs_pkg::C_EX_SET : sacs_pkg::C_EX_Q;
      sacs_pkg::S_EX_QCHK: cmd = st.len_eq ? sacs_pkg::C_LINK_Q : sacs_pkg::C_CLONE;
      sacs_pkg::S_CL_L1:   cmd = sacs_pkg::C_CL_L1;
      sacs_pkg::S_CL_L2:   cmd = sacs_pkg::C_CL_L2;
      sacs_pkg::S_CL_L3:   cmd = sacs_pkg::C_CL_L3;
      sacs_pkg::S_CP_RD:   cmd = sacs_pkg::C_CP_RD;
      sacs_pkg::S_CP_WR:   cmd = sacs_pkg::C_CP_WR;
      sacs_pkg::S_RD_RD:   cmd = st.p_none ? sacs_pkg::C_NONE : sacs_pkg::C_RD_RD;
      sacs_pkg::S_RD_CHK:  cmd = st.t_eq_q ? sacs_pkg::C_RD_SET : sacs_pkg::C_NONE;
      sacs_pkg::S_EX_FIN:  cmd = sacs_pkg::C_EX_FIN;
      sacs_pkg::S_M_RD:    cmd = st.p_none ? sacs_pkg::C_M_ZERO : sacs_pkg::C_M_RD;
      sacs_pkg::S_M_CHK:   cmd = st.t_none ? sacs_pkg::C_M_WALK : sacs_pkg::C_M_HIT;
      sacs_pkg::S_DONE:    cmd = st.out_free ? sacs_pkg::C_PUSH : sacs_pkg::C_NONE;
      default:             cmd = sacs_pkg::C_NONE;
    endcase
  end

endmodule
`default_nettype wire

@@ design/sacs_dpath.sv @@
// Automaton stores, walk registers, match registers and result register.
`default_nettype none
module sacs_dpath #(
  parameter int MAX_TEXT = 1024,
  parameter int ALPHABET = 26
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire sacs_pkg::cmd_t             cmd,
  input  wire logic [sacs_pkg::SYM_W-1:0] sym_in,
  input  wire logic                       out_ready,
  output sacs_pkg::ctl_status_t           st,
  output logic                            out_valid,
  output logic [sacs_pkg::OUT_W-1:0]      out_best,
  output logic [sacs_pkg::OUT_W-1:0]      out_match,
  output logic                            out_status
);

  localparam int STATES = 2 * MAX_TEXT;
  localparam int SIW    = $clog2(STATES);
  localparam int SW     = SIW + 1;
  localparam int LW     = $clog2(MAX_TEXT + 1);
  localparam int IW     = $clog2(ALPHABET);
  localparam int TAW    = $clog2(STATES * ALPHABET);
  localparam logic [SW-1:0] NONE = SW'(STATES);

  logic [SW-1:0] trans_mem [STATES*ALPHABET];
  logic [SW-1:0] link_mem  [STATES];
  logic [LW-1:0] len_mem   [STATES];

  logic [SW-1:0] trans_rd, link_rd;
  logic [LW-1:0] len_rd;

  logic [SW-1:0] count, last, p, q, cur, cl, row, match_state;
  logic [LW-1:0] last_len, new_len, lenp, cur_match, best_match;
  logic [IW-1:0] idx, c;
  logic          first, drop;

  logic           t_we, l_we, n_we;
  logic [TAW-1:0] t_wa, t_ra;
  logic [SW-1:0]  t_wd, l_wd;
  logic [SIW-1:0] l_wa, n_wa, ra;
  logic [LW-1:0]  n_wd, hit_len;

  function automatic logic [TAW-1:0] taddr(logic [SW-1:0] s, logic [IW-1:0] k);
    return TAW'(TAW'(s) * TAW'(ALPHABET)) + TAW'(k);
  endfunction

  assign hit_len = first ? cur_match + LW'(1) : len_rd + LW'(1);

  assign st.p_none   = (p == NONE);
  assign st.t_none   = (trans_rd == NONE);
  assign st.t_eq_q   = (trans_rd == q);
  assign st.len_eq   = (lenp + LW'(1) == len_rd);
  assign st.idx_last = (idx == IW'(ALPHABET - 1));
  assign st.sym_ok   = (int'(sym_in) < ALPHABET);
  assign st.ext_full = (last_len >= LW'(MAX_TEXT)) ||
                       ({1'b0, count} + (SW+1)'(2) > (SW+1)'(STATES));
  assign st.out_free = !out_valid || out_ready;

  always_comb begin
    t_we = 1'b0; t_wa = taddr(p, c); t_wd = NONE; t_ra = taddr(p, c);
    l_we = 1'b0; l_wa = cur[SIW-1:0]; l_wd = NONE;
    n_we = 1'b0; n_wa = count[SIW-1:0]; n_wd = '0;
    ra   = p[SIW-1:0];
    case (cmd)
      sacs_pkg::C_CLEAR: begin
        n_we = 1'b1; n_wa = '0; n_wd = '0;
        l_we = 1'b1; l_wa = '0; l_wd = NONE;
      end
      sacs_pkg::C_EXT_START: begin
        n_we = 1'b1; n_wd = last_len + LW'(1);
      end
      sacs_pkg::C_ROW: begin
        t_we = 1'b1; t_wa = taddr(row, idx); t_wd = NONE;
      end
      sacs_pkg::C_LINK_ROOT: begin
        l_we = 1'b1; l_wd = '0;
      end
      sacs_pkg::C_EX_SET: begin
        t_we = 1'b1; t_wd = cur;
      end
      sacs_pkg::C_EX_Q: ra = trans_rd[SIW-1:0];
      sacs_pkg::C_LINK_Q: begin
        l_we = 1'b1; l_wd = q;
      end
      sacs_pkg::C_CLONE: begin
        n_we = 1'b1; n_wd = lenp + LW'(1);
        ra = q[SIW-1:0];
      end
      sacs_pkg::C_CL_L1: begin
        l_we = 1'b1; l_wa = cl[SIW-1:0]; l_wd = link_rd;
      end
      sacs_pkg::C_CL_L2: begin
        l_we = 1'b1; l_wd = cl;
      end
      sacs_pkg::C_CL_L3: begin
        l_we = 1'b1; l_wa = q[SIW-1:0]; l_wd = cl;
      end
      sacs_pkg::C_CP_RD: t_ra = taddr(q, idx);
      sacs_pkg::C_CP_WR: begin
        t_we = 1'b1; t_wa = taddr(cl, idx); t_wd = trans_rd;
      end
      sacs_pkg::C_RD_SET: begin
        t_we = 1'b1; t_wd = cl;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (t_we) trans_mem[t_wa] <= t_wd;
    trans_rd <= trans_mem[t_ra];
  end

  always_ff @(posedge clk) begin
    if (l_we) link_mem[l_wa] <= l_wd;
    link_rd <= link_mem[ra];
  end

  always_ff @(posedge clk) begin
    if (n_we) len_mem[n_wa] <= n_wd;
    len_rd <= len_mem[ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd == sacs_pkg::C_PUSH) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= SW'(1);
      last        <= '0;
      last_len    <= '0;
      match_state <= '0;
      cur_match   <= '0;
      best_match  <= '0;
      drop        <= 1'b0;
    end else begin
      case (cmd)
        sacs_pkg::C_CLEAR: begin
          count <= SW'(1); last <= '0; last_len <= '0;
          row <= '0; idx <= '0;
          match_state <= '0; cur_match <= '0; best_match <= '0; drop <= 1'b0;
        end
        sacs_pkg::C_EXT_SKIP: begin
          match_state <= '0; cur_match <= '0; best_match <= '0;
          drop <= st.sym_ok;
        end
        sacs_pkg::C_EXT_START: begin
          c <= IW'(sym_in); cur <= count; count <= count + SW'(1);
          new_len <= last_len + LW'(1); row <= count; idx <= '0; p <= last;
          match_state <= '0; cur_match <= '0; best_match <= '0; drop <= 1'b0;
        end
        sacs_pkg::C_ROW:    idx <= idx + IW'(1);
        sacs_pkg::C_EX_SET: p <= link_rd;
        sacs_pkg::C_EX_Q: begin
          q <= trans_rd; lenp <= len_rd;
        end
        sacs_pkg::C_CLONE: begin
          cl <= count; count <= count + SW'(1);
        end
        sacs_pkg::C_CL_L3:  idx <= '0;
        sacs_pkg::C_CP_WR:  idx <= idx + IW'(1);
        sacs_pkg::C_RD_SET: p <= link_rd;
        sacs_pkg::C_EX_FIN: begin
          last <= cur; last_len <= new_len;
        end
        sacs_pkg::C_M_START: begin
          c <= IW'(sym_in); p <= match_state; first <= 1'b1; drop <= 1'b0;
        end
        sacs_pkg::C_M_ZERO: begin
          cur_match <= '0; match_state <= '0; drop <= 1'b0;
        end
        sacs_pkg::C_M_WALK: begin
          p <= link_rd; first <= 1'b0;
        end
        sacs_pkg::C_M_HIT: begin
          cur_match <= hit_len; match_state <= trans_rd;
          if (hit_len > best_match) best_match <= hit_len;
        end
        sacs_pkg::C_OP3: drop <= 1'b0;
        sacs_pkg::C_PUSH: begin
          out_best   <= sacs_pkg::OUT_W'(best_match);
          out_match  <= sacs_pkg::OUT_W'(cur_match);
          out_status <= drop;
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ design/sacs_checker.sv @@
// Port checker for the suffix automaton block and its bind.
`default_nettype none
module sacs_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [sacs_pkg::OUT_W-1:0] best_length,
  input wire logic [sacs_pkg::OUT_W-1:0] match_length,
  input wire logic                       status
);

  // Hold a stalled response.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(best_length) &&
    $stable(match_length) && $stable(status))
    else $error("stalled response changed");

  // One item at a time: ready drops after a transfer.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  a_drop_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> best_length == '0 && match_length == '0)
    else $error("dropped extend reports lengths");

  a_best_ge: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> match_length <= best_length)
    else $error("match length above best length");

endmodule

bind suffix_automaton_common_substring sacs_checker u_sacs_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (req.valid),
  .in_ready     (req.ready),
  .out_valid    (rsp.valid),
  .out_ready    (rsp.ready),
  .best_length  (rsp.best_length),
  .match_length (rsp.match_length),
  .status       (rsp.status)
);
`default_nettype wire

@@ dv/suffix_automaton_common_substring_tb.sv @@
// Testbench for the suffix automaton common substring block: directed table plus random runs.
`default_nettype none
module suffix_automaton_common_substring_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_TEXT = 1024;
  localparam int ALPHABET = 26;
  localparam int STATES   = 2 * MAX_TEXT;
  localparam int NONE     = STATES;
  localparam logic [sacs_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  // Expected response of one request.
  typedef struct packed {
    logic [sacs_pkg::OUT_W-1:0] best_length;
    logic [sacs_pkg::OUT_W-1:0] match_length;
    logic                       status;
  } sa_result_t;

  localparam sa_result_t R_OK   = '0;
  localparam sa_result_t R_DROP = '{best_length: '0, match_length: '0, status: 1'b1};

  // One directed row: the request, plus an optional typed-in answer.
  typedef struct {
    logic [sacs_pkg::OP_W-1:0]  operation;
    logic [sacs_pkg::SYM_W-1:0] symbol;
    bit                         known;
    sa_result_t                 answer;
  } sa_row_t;

  logic clk;
  logic rst;

  sacs_req_if req ();
  sacs_rsp_if rsp ();

  suffix_automaton_common_substring #(
    .MAX_TEXT(MAX_TEXT),
    .ALPHABET(ALPHABET)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .req(req.sink),
    .rsp(rsp.source)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Shadow automaton: same structure as the block, kept in plain arrays.
  int unsigned next_of [STATES][ALPHABET];
  int unsigned len_of  [STATES];
  int unsigned link_of [STATES];
  int unsigned n_states;
  int unsigned tail_state;
  int unsigned walk_state;
  int unsigned run_len;
  int unsigned best_len;

  sa_result_t expected_q[$];
  int mismatches;
  int seen_results;
  int drops_seen;
  int clones_made;

  // Idling knobs, percent of cycles, plus a receiver hold count.
  int send_idle_pct;
  int recv_idle_pct;
  int hold_cycles;

  function automatic int unsigned sa_add_state(int unsigned len);
    int unsigned s;
    s = n_states;
    for (int c = 0; c < ALPHABET; c++) next_of[s][c] = NONE;
    len_of[s] = len;
    link_of[s] = NONE;
    n_states++;
    return s;
  endfunction

  function automatic void sa_clear();
    n_states = 0;
    void'(sa_add_state(0));
    tail_state = 0;
    walk_state = 0;
    run_len = 0;
    best_len = 0;
  endfunction

  function automatic int unsigned sa_go(int unsigned s, int unsigned c);
    if (s >= STATES || c >= ALPHABET) return NONE;
    return next_of[s][c];
  endfunction

  // Append one letter; returns 1 when the store has no room.
  function automatic bit sa_extend(int unsigned c);
    int unsigned cur, p, q, cl;
    if (c >= ALPHABET) return 1'b0;
    if (len_of[tail_state] >= MAX_TEXT || n_states + 2 > STATES) return 1'b1;
    cur = sa_add_state(len_of[tail_state] + 1);
    p = tail_state;
    while (p != NONE && sa_go(p, c) == NONE) begin
      next_of[p][c] = cur;
      p = link_of[p];
    end
    if (p == NONE) begin
      link_of[cur] = 0;
    end else begin
      q = sa_go(p, c);
      if (len_of[p] + 1 == len_of[q]) begin
        link_of[cur] = q;
      end else begin
        cl = sa_add_state(len_of[p] + 1);
        clones_made++;
        for (int k = 0; k < ALPHABET; k++) next_of[cl][k] = next_of[q][k];
        link_of[cl] = link_of[q];
        link_of[cur] = cl;
        link_of[q] = cl;
        while (p != NONE && sa_go(p, c) == q) begin
          next_of[p][c] = cl;
          p = link_of[p];
        end
      end
    end
    tail_state = cur;
    return 1'b0;
  endfunction

  function automatic void sa_match(int unsigned c);
    int unsigned s, t;
    s = walk_state;
    t = sa_go(s, c);
    if (t != NONE) begin
      run_len++;
      walk_state = t;
    end else begin
      while (s != NONE && sa_go(s, c) == NONE) s = link_of[s];
      if (s == NONE) begin
        run_len = 0;
        walk_state = 0;
        return;
      end
      run_len = len_of[s] + 1;
      walk_state = sa_go(s, c);
    end
    if (run_len > best_len) best_len = run_len;
  endfunction

  // Predict the response of one accepted request and advance the shadow.
  function automatic sa_result_t sa_predict(logic [sacs_pkg::OP_W-1:0] op,
                                            logic [sacs_pkg::SYM_W-1:0] sym);
    sa_result_t r;
    r = '0;
    case (op)
      sacs_pkg::OP_CLEAR: begin
        sa_clear();
      end
      sacs_pkg::OP_EXTEND: begin
        r.status = sa_extend(int'(sym));
        walk_state = 0;
        run_len = 0;
        best_len = 0;
      end
      default: begin
        if (op == sacs_pkg::OP_MATCH) sa_match(int'(sym));
        r.best_length  = best_len[sacs_pkg::OUT_W-1:0];
        r.match_length = run_len[sacs_pkg::OUT_W-1:0];
      end
    endcase
    return r;
  endfunction

  // Drive one request; hold it until the transfer, idling as configured.
  task automatic send_item(logic [sacs_pkg::OP_W-1:0] op, logic [sacs_pkg::SYM_W-1:0] sym,
                           bit known, sa_result_t answer);
    sa_result_t predicted;
    if ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    end
    req.valid     <= 1'b1;
    req.operation <= op;
    req.symbol    <= sym;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    predicted = sa_predict(op, sym);
    if (known && predicted !== answer) begin
      mismatches++;
      if (mismatches <= 10)
        $display("table row op %0d sym %0d: typed %p, predicted %p", op, sym, answer, predicted);
    end
    expected_q.push_back(known ? answer : predicted);
    @(negedge clk);
  endtask

  // Response side: stall at random, or hold off for a counted stretch.
  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        rsp.ready <= 1'b0;
        hold_cycles--;
      end else begin
        rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Compare each transfer with the oldest expectation.
  always @(posedge clk) begin
    sa_result_t got, want;
    if (!rst && rsp.valid && rsp.ready) begin
      got = '{rsp.best_length, rsp.match_length, rsp.status};
      seen_results++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response %p", got);
      end else begin
        want = expected_q.pop_front();
        if (want.status) drops_seen++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected best %0d match %0d status %0d, got %0d %0d %0d",
                     want.best_length, want.match_length, want.status,
                     got.best_length, got.match_length, got.status);
        end
      end
    end
  end

  // Watchdog.
  initial begin
    #50ms;
    $display("timeout");
    $display("suffix_automaton_common_substring_tb NOT OK");
    $finish;
  end

  // Random content: a short text, then queries, most drawn from it.
  task automatic random_phase(int n_items);
    int sent;
    int text_len;
    int alpha;
    int n_query;
    logic [sacs_pkg::SYM_W-1:0] text[$];
    sent = 0;
    while (sent < n_items) begin
      // Small alphabets give repeats and therefore clones and link walks.
      alpha = $urandom_range(1, 4) == 1 ? ALPHABET : $urandom_range(2, 4);
      text_len = $urandom_range(1, 30);
      text.delete();
      send_item(sacs_pkg::OP_CLEAR, sacs_pkg::SYM_W'($urandom), 1'b0, R_OK);
      sent++;
      for (int i = 0; i < text_len; i++) begin
        text.push_back(sacs_pkg::SYM_W'($urandom_range(alpha - 1)));
        send_item(sacs_pkg::OP_EXTEND, text[i], 1'b0, R_OK);
        sent++;
      end
      n_query = $urandom_range(4, 30);
      for (int i = 0; i < n_query; i++) begin
        case ($urandom_range(9))
          0: send_item(sacs_pkg::OP_MATCH, sacs_pkg::SYM_W'($urandom), 1'b0, R_OK);
          1: send_item(OP_UNUSED, sacs_pkg::SYM_W'($urandom), 1'b0, R_OK);
          2, 3: send_item(sacs_pkg::OP_MATCH, sacs_pkg::SYM_W'($urandom_range(alpha - 1)),
                          1'b0, R_OK);
          default: send_item(sacs_pkg::OP_MATCH, text[$urandom_range(text.size() - 1)],
                             1'b0, R_OK);
        endcase
        sent++;
      end
      // Now and then an extend after the queries wipes the match.
      if ($urandom_range(4) == 0) begin
        send_item(sacs_pkg::OP_EXTEND, sacs_pkg::SYM_W'($urandom), 1'b0, R_OK);
        sent++;
      end
    end
  endtask

  // Fill the store to its text limit so the drop path is exercised.
  task automatic fill_phase();
    send_item(sacs_pkg::OP_CLEAR, '0, 1'b0, R_OK);
    for (int i = 0; i < MAX_TEXT; i++)
      send_item(sacs_pkg::OP_EXTEND, sacs_pkg::SYM_W'($urandom_range(1)), 1'b0, R_OK);
    send_item(sacs_pkg::OP_EXTEND, 5'd0, 1'b1, R_DROP);
    send_item(sacs_pkg::OP_EXTEND, 5'd25, 1'b1, R_DROP);
    for (int i = 0; i < 20; i++)
      send_item(sacs_pkg::OP_MATCH, sacs_pkg::SYM_W'($urandom_range(1)), 1'b0, R_OK);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    while (expected_q.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (200) @(posedge clk);
  endtask

  sa_row_t directed[$];

  initial begin
    mismatches = 0;
    seen_results = 0;
    drops_seen = 0;
    clones_made = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles = 0;
    req.valid = 1'b0;
    req.operation = sacs_pkg::OP_CLEAR;
    req.symbol = '0;
    sa_clear();
    rst = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table: extremes, every operation, each special case.
    directed = '{
      '{sacs_pkg::OP_MATCH,  5'd0,  1'b1, R_OK},   // empty automaton: no match
      '{OP_UNUSED,           5'd31, 1'b1, R_OK},   // unused code reports match state
      '{sacs_pkg::OP_EXTEND, 5'd0,  1'b1, R_OK},
      '{sacs_pkg::OP_EXTEND, 5'd1,  1'b1, R_OK},
      '{sacs_pkg::OP_EXTEND, 5'd0,  1'b1, R_OK},
      '{sacs_pkg::OP_EXTEND, 5'd1,  1'b1, R_OK},
      '{sacs_pkg::OP_EXTEND, 5'd1,  1'b1, R_OK},   // "ababb" forces a clone
      '{sacs_pkg::OP_EXTEND, 5'd31, 1'b1, R_OK},   // out-of-range letter ignored
      '{sacs_pkg::OP_EXTEND, 5'd26, 1'b1, R_OK},
      '{sacs_pkg::OP_MATCH,  5'd0,  1'b0, R_OK},
      '{sacs_pkg::OP_MATCH,  5'd1,  1'b0, R_OK},
      '{sacs_pkg::OP_MATCH,  5'd0,  1'b0, R_OK},
      '{sacs_pkg::OP_MATCH,  5'd1,  1'b0, R_OK},
      '{sacs_pkg::OP_MATCH,  5'd1,  1'b0, R_OK},
      '{sacs_pkg::OP_MATCH,  5'd1,  1'b0, R_OK},   // mismatch walks suffix links
      '{sacs_pkg::OP_MATCH,  5'd25, 1'b0, R_OK},   // letter never seen
      '{sacs_pkg::OP_MATCH,  5'd31, 1'b0, R_OK},   // out-of-range in a match
      '{sacs_pkg::OP_MATCH,  5'd0,  1'b0, R_OK},
      '{OP_UNUSED,           5'd0,  1'b0, R_OK},
      '{sacs_pkg::OP_EXTEND, 5'd25, 1'b1, R_OK},   // extend wipes match state
      '{OP_UNUSED,           5'd0,  1'b1, R_OK},
      '{sacs_pkg::OP_CLEAR,  5'd31, 1'b1, R_OK},
      '{sacs_pkg::OP_MATCH,  5'd0,  1'b1, R_OK}
    };
    foreach (directed[i])
      send_item(directed[i].operation, directed[i].symbol,
                directed[i].known, directed[i].answer);

    // Sender idles lightly, receiver heavily.
    send_idle_pct = 27;
    recv_idle_pct = 85;
    random_phase(50);

    // Swap the idling; hold the receiver off while requests keep coming.
    recv_idle_pct = 27;
    hold_cycles = 3000;
    send_idle_pct = 0;
    random_phase(20);
    send_idle_pct = 85;
    random_phase(30);

    // No idling on either side, then the full-store case.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(50);
    fill_phase();
    req.valid <= 1'b0;

    drain();
    $display("covered %0d responses, %0d clones, %0d dropped extends",
             seen_results, clones_made, drops_seen);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("suffix_automaton_common_substring_tb OK");
    end else begin
      $display("%0d failures, %0d responses outstanding", mismatches, expected_q.size());
      $display("suffix_automaton_common_substring_tb NOT OK");
    end
    $finish;
  end
endmodule
`default_nettype wire

@@ sim.f @@
design/sacs_pkg.sv
design/sacs_if.sv
design/sacs_ctrl.sv
design/sacs_dpath.sv
design/suffix_automaton_common_substring.sv
design/sacs_checker.sv
dv/suffix_automaton_common_substring_tb.sv
